@@ rtl/jbss_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON bracket scanner package
// Shared constants, status codes, character codes and types of the scanner.
// ----------------------------------------------------------------------------
package jbss_pkg;

	localparam int DEPTH_BITS = 16;
	localparam int OUT_DEPTH_W = 16;

	localparam logic [2:0] ST_PLAIN     = 3'd0;
	localparam logic [2:0] ST_SEP       = 3'd1;
	localparam logic [2:0] ST_CLOSE_OK  = 3'd2;
	localparam logic [2:0] ST_CLOSE_BAD = 3'd3;
	localparam logic [2:0] ST_NOT_CONT  = 3'd4;
	localparam logic [2:0] ST_UNTERM    = 3'd5;
	localparam logic [2:0] ST_IDLE      = 3'd6;
	localparam logic [2:0] ST_OVERFLOW  = 3'd7;

	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_NUL    = 8'h00;

	localparam logic [DEPTH_BITS-1:0] LEVEL_MAX = {DEPTH_BITS{1'b1}};
	localparam logic [DEPTH_BITS-1:0] LEVEL_ONE = DEPTH_BITS'(1);

	typedef struct packed {
		logic                  active;
		logic                  in_quotes;
		logic                  skip_next;
		logic [DEPTH_BITS-1:0] level;
		logic                  as_object;
	} scan_state_t;

	typedef struct packed {
		logic [2:0]             status;
		logic [OUT_DEPTH_W-1:0] nest_depth;
		logic                   inside_string;
	} scan_result_t;

	function automatic logic [OUT_DEPTH_W-1:0] depth_out(input logic [DEPTH_BITS-1:0] lvl);
		logic [DEPTH_BITS+OUT_DEPTH_W-1:0] ext;
		ext = {{OUT_DEPTH_W{1'b0}}, lvl};
		return ext[OUT_DEPTH_W-1:0];
	endfunction

endpackage

@@ rtl/json_bracket_structure_scanner.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON bracket structure scanner
// Follows the bracket nesting of one JSON container and reports a status,
// the nesting depth and the in-string flag for every byte of text.
// ----------------------------------------------------------------------------
// Usage:
// Bytes of JSON text enter on the input channel (in_valid, in_stall,
// data_byte, start_scan); a byte is taken at a clock edge where in_valid is
// high and in_stall is low. Every byte gives exactly one result word on the
// output channel (out_valid, out_stall, status, nest_depth, inside_string).
// A byte goes through an input register and then a result register before
// its word is on the output. One byte is taken in every cycle while the
// receiver keeps out_stall low; the scan state is updated by combinational
// flag and counter logic between the two registers.
// When the receiver stalls, the result word holds and one further byte is
// kept in the input register; in_stall then rises until the result drains.
// Reset clears the valid flags of both registers and the scan state, so no
// scan is active and no word is pending.
// ----------------------------------------------------------------------------
module json_bracket_structure_scanner (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [7:0]                       data_byte,
	input  logic                             start_scan,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [2:0]                       status,
	output logic [jbss_pkg::OUT_DEPTH_W-1:0] nest_depth,
	output logic                             inside_string
);
	import jbss_pkg::*;

	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         start_s1;
	logic         valid_s2;
	scan_result_t res_s2;
	scan_state_t  state_q;
	scan_state_t  state_nxt;
	scan_result_t res_nxt;
	logic         adv_s2;
	logic         adv_s1;

	assign adv_s2 = !valid_s2 || !out_stall;
	assign adv_s1 = !valid_s1 || adv_s2;
	assign in_stall = !adv_s1;

	jbss_step u_step (
		.cur        (state_q),
		.data_byte  (byte_s1),
		.start_scan (start_s1),
		.nxt        (state_nxt),
		.res        (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q <= '0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= in_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
				if (valid_s1) begin
					state_q <= state_nxt;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			byte_s1 <= data_byte;
			start_s1 <= start_scan;
		end
		if (adv_s2 && valid_s1) begin
			res_s2 <= res_nxt;
		end
	end

	assign out_valid = valid_s2;
	assign status = res_s2.status;
	assign nest_depth = res_s2.nest_depth;
	assign inside_string = res_s2.inside_string;

endmodule

@@ rtl/jbss_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON bracket scanner step logic
// Works out the status of one byte and the scan state that follows it.
// ----------------------------------------------------------------------------
module jbss_step (
	input  jbss_pkg::scan_state_t  cur,
	input  logic [7:0]             data_byte,
	input  logic                   start_scan,
	output jbss_pkg::scan_state_t  nxt,
	output jbss_pkg::scan_result_t res
);
	import jbss_pkg::*;

	logic [DEPTH_BITS-1:0] lvl_inc;
	logic [DEPTH_BITS-1:0] lvl_dec;

	assign lvl_inc = cur.level + LEVEL_ONE;
	assign lvl_dec = cur.level - LEVEL_ONE;

	always_comb begin
		nxt = cur;
		res.status = ST_PLAIN;
		res.nest_depth = depth_out(cur.level);
		res.inside_string = 1'b0;
		if (start_scan) begin
			nxt = '0;
			if (data_byte == CH_LBRACE || data_byte == CH_LBRACK) begin
				nxt.active = 1'b1;
				nxt.level = LEVEL_ONE;
				nxt.as_object = (data_byte == CH_LBRACE);
				res.nest_depth = depth_out(LEVEL_ONE);
			end else begin
				res.status = ST_NOT_CONT;
				res.nest_depth = '0;
			end
		end else if (!cur.active) begin
			res.status = ST_IDLE;
			res.nest_depth = '0;
		end else if (data_byte == CH_NUL) begin
			res.status = ST_UNTERM;
			res.inside_string = cur.in_quotes;
			nxt = '0;
		end else if (cur.in_quotes) begin
			res.inside_string = 1'b1;
			if (cur.skip_next) begin
				nxt.skip_next = 1'b0;
			end else if (data_byte == CH_QUOTE) begin
				nxt.in_quotes = 1'b0;
			end else if (data_byte == CH_BSLASH) begin
				nxt.skip_next = 1'b1;
			end
		end else begin
			case (data_byte) inside
				CH_QUOTE: begin
					nxt.in_quotes = 1'b1;
					res.inside_string = 1'b1;
				end
				CH_LBRACE, CH_LBRACK: begin
					if (cur.level == LEVEL_MAX) begin
						res.status = ST_OVERFLOW;
						nxt = '0;
					end else begin
						nxt.level = lvl_inc;
						res.nest_depth = depth_out(lvl_inc);
					end
				end
				CH_RBRACE, CH_RBRACK: begin
					res.nest_depth = depth_out(lvl_dec);
					if (lvl_dec == '0) begin
						nxt = '0;
						if (cur.as_object == (data_byte == CH_RBRACE)) begin
							res.status = ST_CLOSE_OK;
						end else begin
							res.status = ST_CLOSE_BAD;
						end
					end else begin
						nxt.level = lvl_dec;
					end
				end
				CH_COMMA: begin
					if (cur.level == LEVEL_ONE) begin
						res.status = ST_SEP;
					end
				end
				default: begin
					res.status = ST_PLAIN;
				end
			endcase
		end
	end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON bracket structure scanner testbench
// Sends bytes of JSON text through the scanner and compares every result
// word against a cycle-free model of the bracket, string and escape logic
// or a typed word. A short table of hand-picked bytes comes first. Where
// the depth counter is narrow, a run up to the deepest nesting and its
// overflow follows. Random text that is mostly built from well-formed
// fragments comes last. Both sides of the block idle in random bursts.
// ----------------------------------------------------------------------------
module testbench;
	import jbss_pkg::*;

	localparam int RANDOM_WORDS = 550;
	localparam int CYCLE_LIMIT  = 5_000_000;
	localparam int DIR_N        = 27;

	typedef struct packed {
		logic [2:0]             status;
		logic [OUT_DEPTH_W-1:0] depth;
		logic                   in_str;
	} word_t;

	typedef struct packed {
		logic [7:0] data;
		logic       start;
		logic       typed;
		word_t      word;
	} row_t;

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_stall;
	logic [7:0]             data_byte;
	logic                   start_scan;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic [2:0]             status;
	logic [OUT_DEPTH_W-1:0] nest_depth;
	logic                   inside_string;

	// Predicted scan state.
	logic                  sc_active;
	logic                  sc_quoted;
	logic                  sc_skip;
	logic [DEPTH_BITS-1:0] sc_level;
	logic                  sc_object;

	word_t pending_words[$];
	word_t got_word;
	word_t want_word;
	int    fault_count;
	int    sent_count;
	int    cycle_count;
	int    stall_left;
	int    deepest;
	int    status_seen [8];
	bit    quiet;

	// Hand-picked bytes; rows with typed set carry their own expected word.
	row_t dir_rows [DIR_N] = '{
		{"x",       1'b0, 1'b1, ST_IDLE,      16'd0, 1'b0},
		{CH_NUL,    1'b0, 1'b1, ST_IDLE,      16'd0, 1'b0},
		{"a",       1'b1, 1'b1, ST_NOT_CONT,  16'd0, 1'b0},
		{CH_LBRACE, 1'b1, 1'b1, ST_PLAIN,     16'd1, 1'b0},
		{CH_QUOTE,  1'b0, 1'b0, ST_PLAIN,     16'd0, 1'b0},
		{CH_BSLASH, 1'b0, 1'b0, ST_PLAIN,     16'd0, 1'b0},
		{CH_NUL,    1'b0, 1'b1, ST_UNTERM,    16'd1, 1'b1},
		{CH_LBRACK, 1'b1, 1'b1, ST_PLAIN,     16'd1, 1'b0},
		{CH_COMMA,  1'b0, 1'b1, ST_SEP,       16'd1, 1'b0},
		{CH_LBRACE, 1'b0, 1'b0, ST_PLAIN,     16'd0, 1'b0},
		{CH_COMMA,  1'b0, 1'b0, ST_PLAIN,     16'd0, 1'b0},
		{CH_QUOTE,  1'b0, 1'b0, ST_PLAIN,     16'd0, 1'b0},
		{CH_BSLASH, 1'b0, 1'b0, ST_PLAIN,     16'd0, 1'b0},
		{CH_QUOTE,  1'b0, 1'b0, ST_PLAIN,     16'd0, 1'b0},
		{CH_RBRACE, 1'b0, 1'b0, ST_PLAIN,     16'd0, 1'b0},
		{CH_COMMA,  1'b0, 1'b0, ST_PLAIN,     16'd0, 1'b0},
		{CH_QUOTE,  1'b0, 1'b0, ST_PLAIN,     16'd0, 1'b0},
		{CH_BSLASH, 1'b0, 1'b0, ST_PLAIN,     16'd0, 1'b0},
		{CH_RBRACK, 1'b0, 1'b0, ST_PLAIN,     16'd0, 1'b0},
		{CH_RBRACE, 1'b0, 1'b1, ST_CLOSE_BAD, 16'd0, 1'b0},
		{CH_LBRACK, 1'b1, 1'b1, ST_PLAIN,     16'd1, 1'b0},
		{CH_LBRACE, 1'b1, 1'b1, ST_PLAIN,     16'd1, 1'b0},
		{8'hFF,     1'b0, 1'b0, ST_PLAIN,     16'd0, 1'b0},
		{CH_RBRACE, 1'b0, 1'b1, ST_CLOSE_OK,  16'd0, 1'b0},
		{CH_LBRACK, 1'b1, 1'b1, ST_PLAIN,     16'd1, 1'b0},
		{CH_NUL,    1'b0, 1'b1, ST_UNTERM,    16'd1, 1'b0},
		{8'hFF,     1'b0, 1'b1, ST_IDLE,      16'd0, 1'b0}
	};

	json_bracket_structure_scanner uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.data_byte     (data_byte),
		.start_scan    (start_scan),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.nest_depth    (nest_depth),
		.inside_string (inside_string)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic void clear_scan();
		sc_active = 1'b0;
		sc_quoted = 1'b0;
		sc_skip   = 1'b0;
		sc_level  = '0;
		sc_object = 1'b0;
	endfunction

	function automatic word_t scan_predict(input logic [7:0] b, input logic st);
		word_t w;
		w = '{status: ST_PLAIN, depth: '0, in_str: 1'b0};
		if (st) begin
			clear_scan();
			if (b == CH_LBRACE || b == CH_LBRACK) begin
				sc_active = 1'b1;
				sc_level  = LEVEL_ONE;
				sc_object = (b == CH_LBRACE);
				w.depth   = OUT_DEPTH_W'(sc_level);
			end else begin
				w.status = ST_NOT_CONT;
			end
		end else if (!sc_active) begin
			w.status = ST_IDLE;
		end else if (b == CH_NUL) begin
			w = '{status: ST_UNTERM, depth: OUT_DEPTH_W'(sc_level), in_str: sc_quoted};
			clear_scan();
		end else if (sc_quoted) begin
			if (sc_skip)
				sc_skip = 1'b0;
			else if (b == CH_QUOTE)
				sc_quoted = 1'b0;
			else if (b == CH_BSLASH)
				sc_skip = 1'b1;
			w.depth  = OUT_DEPTH_W'(sc_level);
			w.in_str = 1'b1;
		end else begin
			case (b)
				CH_QUOTE: begin
					sc_quoted = 1'b1;
					w.depth   = OUT_DEPTH_W'(sc_level);
					w.in_str  = 1'b1;
				end
				CH_LBRACE, CH_LBRACK: begin
					if (sc_level == LEVEL_MAX) begin
						w.status = ST_OVERFLOW;
						w.depth  = OUT_DEPTH_W'(LEVEL_MAX);
						clear_scan();
					end else begin
						sc_level = sc_level + 1'b1;
						w.depth  = OUT_DEPTH_W'(sc_level);
					end
				end
				CH_RBRACE, CH_RBRACK: begin
					sc_level = sc_level - 1'b1;
					if (sc_level == '0) begin
						w.status = ((b == CH_RBRACE) == sc_object) ? ST_CLOSE_OK : ST_CLOSE_BAD;
						clear_scan();
					end else begin
						w.depth = OUT_DEPTH_W'(sc_level);
					end
				end
				CH_COMMA: begin
					w.status = (sc_level == LEVEL_ONE) ? ST_SEP : ST_PLAIN;
					w.depth  = OUT_DEPTH_W'(sc_level);
				end
				default: begin
					w.depth = OUT_DEPTH_W'(sc_level);
				end
			endcase
		end
		return w;
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic st, input logic typed,
			input word_t typed_word);
		word_t w;
		if (!quiet && $urandom_range(0, 11) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		data_byte  <= b;
		start_scan <= st;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		w = scan_predict(b, st);
		pending_words.push_back(typed ? typed_word : w);
		sent_count++;
	endtask

	// Random text: mostly brackets, strings, escapes and commas that keep a
	// scan alive, with stray bytes, restarts and early ends mixed in.
	task automatic pick_byte(output logic [7:0] b, output logic st);
		int r;
		r  = $urandom_range(0, 99);
		st = 1'b0;
		if (!sc_active) begin
			if (r < 75) begin
				st = 1'b1;
				b  = $urandom_range(0, 1) ? CH_LBRACE : CH_LBRACK;
			end else if (r < 85) begin
				st = 1'b1;
				b  = 8'($urandom_range(0, 255));
			end else begin
				b = 8'($urandom_range(0, 255));
			end
		end else if (r == 0) begin
			st = 1'b1;
			b  = 8'($urandom_range(0, 255));
		end else if (r == 1) begin
			b = CH_NUL;
		end else if (sc_quoted) begin
			if (r < 15)
				b = CH_BSLASH;
			else if (r < 35)
				b = CH_QUOTE;
			else
				b = 8'($urandom_range(1, 255));
		end else if (r < 12) begin
			b = CH_QUOTE;
		end else if (r < 28 && sc_level < 8) begin
			b = $urandom_range(0, 1) ? CH_LBRACE : CH_LBRACK;
		end else if (r < 48) begin
			b = $urandom_range(0, 1) ? CH_RBRACE : CH_RBRACK;
		end else if (r < 60) begin
			b = CH_COMMA;
		end else begin
			b = 8'($urandom_range(1, 255));
		end
	endtask

	initial begin
		logic [7:0] b;
		logic       st;
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		data_byte  <= '0;
		start_scan <= 1'b0;
		quiet      = 1'b0;
		clear_scan();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIR_N; i++)
			send_byte(dir_rows[i].data, dir_rows[i].start, dir_rows[i].typed, dir_rows[i].word);

		in_valid <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);

		// Climb to the deepest level, step back once, then overflow. This only
		// fits the length of the run when the depth counter is narrow.
		if (DEPTH_BITS <= 6) begin
			send_byte(CH_LBRACK, 1'b1, 1'b0, '0);
			for (int k = 1; k < int'(LEVEL_MAX); k++)
				send_byte(CH_LBRACE, 1'b0, 1'b0, '0);
			send_byte(CH_RBRACK, 1'b0, 1'b0, '0);
			send_byte(CH_LBRACK, 1'b0, 1'b0, '0);
			send_byte(CH_LBRACE, 1'b0, 1'b1,
				'{status: ST_OVERFLOW, depth: OUT_DEPTH_W'(LEVEL_MAX), in_str: 1'b0});
			send_byte(CH_COMMA, 1'b0, 1'b1, '{status: ST_IDLE, depth: '0, in_str: 1'b0});
		end

		for (int i = 0; i < RANDOM_WORDS; i++) begin
			if (i == RANDOM_WORDS / 2) begin
				in_valid <= 1'b0;
				while (pending_words.size() != 0) @(posedge clk);
			end
			if (i == RANDOM_WORDS - 60)
				quiet = 1'b1;
			pick_byte(b, st);
			send_byte(b, st, 1'b0, '0);
		end
		in_valid <= 1'b0;

		while (pending_words.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("%0d words sent: %0d separators, %0d good closes, %0d bad closes, %0d unterminated,",
			sent_count, status_seen[ST_SEP], status_seen[ST_CLOSE_OK],
			status_seen[ST_CLOSE_BAD], status_seen[ST_UNTERM]);
		$display("%0d not a container, %0d idle, %0d overflow; deepest nesting seen %0d.",
			status_seen[ST_NOT_CONT], status_seen[ST_IDLE], status_seen[ST_OVERFLOW], deepest);
		if (fault_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			got_word = '{status: status, depth: nest_depth, in_str: inside_string};
			status_seen[status]++;
			if (int'(nest_depth) > deepest)
				deepest = int'(nest_depth);
			if (pending_words.size() == 0) begin
				fault_count++;
				$display("%0t: word with nothing expected: status %0d, depth %0d, string %0b",
					$time, status, nest_depth, inside_string);
			end else begin
				want_word = pending_words.pop_front();
				if (got_word.status !== want_word.status) begin
					fault_count++;
					$display("%0t: status expected %0d, actual %0d",
						$time, want_word.status, got_word.status);
				end
				if (got_word.depth !== want_word.depth) begin
					fault_count++;
					$display("%0t: nest_depth expected %0d, actual %0d",
						$time, want_word.depth, got_word.depth);
				end
				if (got_word.in_str !== want_word.in_str) begin
					fault_count++;
					$display("%0t: inside_string expected %0b, actual %0b",
						$time, want_word.in_str, got_word.in_str);
				end
			end
		end

		if (stall_left == 0 && !quiet && $urandom_range(0, 15) == 0)
			stall_left = $urandom_range(1, 11);
		out_stall <= (stall_left != 0);
		if (stall_left != 0)
			stall_left--;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

endmodule
